// File: sv/nvsq_pkg.sv
// Shared types, operation codes and the note period table of the square-wave tone generator.
`default_nettype none

package nvsq_pkg;

   // Operation codes carried by an input item
   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;

   localparam int NOTE_COUNT = 128;

   // Input item
   typedef struct packed {
      logic [1:0]  operation;
      logic [6:0]  note;
      logic [15:0] elapsed_us;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] toggle_mask;
      logic       voice_found;
      logic [2:0] voice_index;
      logic [7:0] released_mask;
   } rsp_type;

   // One voice entry as held in the voice memory
   typedef struct packed {
      logic        playing;
      logic [6:0]  note;
      logic [15:0] period;
      logic [15:0] countdown;
   } voice_type;

   // Per-voice outcome of one update step
   typedef struct packed {
      logic taken;
      logic released;
      logic toggled;
   } voice_flags_type;

   typedef logic [15:0] period_rom_type [NOTE_COUNT];

   // 2^(r/12) scaled by 10^12
   localparam logic [63:0] SEMITONE [12] = '{
      64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115003,
      64'd1259921049895, 64'd1334839854170, 64'd1414213562373, 64'd1498307076877,
      64'd1587401051968, 64'd1681792830507, 64'd1781797436281, 64'd1887748625363
   };

   // Half period in microseconds: 25000 * 2^((57 - i) twelfths) over 11, floored, saturated.
   // 129 - i is kept as 12 * s + r, starting at s = 10, r = 9 for note 0.
   function automatic period_rom_type build_period_rom();
      period_rom_type rom;
      int unsigned    s;
      int unsigned    r;
      logic [63:0]    num;
      logic [63:0]    den;
      logic [63:0]    v;
      logic [63:0]    rem;
      s = 10;
      r = 9;
      for (int i = 0; i < NOTE_COUNT; i++) begin
         num = SEMITONE[r] * 64'd25000;
         den = 64'd11000000000000;
         if (s >= 6) begin
            num = num << (s - 6);
         end else begin
            den = den << (6 - s);
         end
         // restoring long division of num by den
         v   = '0;
         rem = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem  = rem - den;
               v[b] = 1'b1;
            end
         end
         if (v > 64'hFFFF) begin
            v = 64'hFFFF;
         end
         rom[i] = v[15:0];
         // next note is one semitone up
         if (r == 0) begin
            r = 11;
            s = s - 1;
         end else begin
            r = r - 1;
         end
      end
      return rom;
   endfunction

   localparam period_rom_type PERIOD_ROM = build_period_rom();

endpackage

`default_nettype wire

// File: sv/nvsq_voice_update.sv
// Read-modify-write step for one voice entry: note on, note off or tick.
`default_nettype none

module nvsq_voice_update (
   input  nvsq_pkg::req_type         item,
   input  nvsq_pkg::voice_type       cur,
   input  logic                      open,
   output nvsq_pkg::voice_type       nxt,
   output nvsq_pkg::voice_flags_type flags
);
   import nvsq_pkg::*;

   logic [15:0] cd_mid;
   logic        fire;

   // countdown reload for a playing voice that has run out
   assign fire   = cur.playing && (cur.countdown == 16'd0);
   assign cd_mid = fire ? cur.period : cur.countdown;

   always_comb begin
      nxt   = cur;
      flags = '0;
      unique case (item.operation)
         OP_NOTE_ON: begin
            if (open && !cur.playing) begin
               nxt.playing = 1'b1;
               nxt.note    = item.note;
               nxt.period  = PERIOD_ROM[item.note];
               flags.taken = 1'b1;
            end
         end
         OP_NOTE_OFF: begin
            if (cur.playing && (cur.note == item.note)) begin
               nxt.playing    = 1'b0;
               flags.released = 1'b1;
            end
         end
         OP_TICK: begin
            flags.toggled = fire;
            nxt.countdown = (cd_mid > item.elapsed_us) ? (cd_mid - item.elapsed_us) : 16'd0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/note_voice_square_wave_generator_unit.sv
// Top level of the polyphonic square-wave tone generator: voice memory and sequencer.
//
//  channel  | ports                            | direction | item
//  ---------+----------------------------------+-----------+--------------------------
//  request  | req_valid, req_stall, req_payload | in       | note on / note off / tick
//  response | rsp_valid, rsp_stall, rsp_payload | out      | masks, voice found, index
//
// An item walks the voice memory: one voice memory read a cycle, each processed entry
// written back, then the walk is left and the output register is loaded with the result.
// The input is stalled from acceptance until the result is loaded, so the next item is
// accepted only once the result of the last one has been loaded.
// One item is worked at a time; a result waiting in the output register does not block
// acceptance of the next item, only the load of its own result.
// Synchronous reset clears the control state and the per-entry valid bits; an entry
// never written reads as all zero, so no clearing pass is needed.
`default_nettype none

module note_voice_square_wave_generator_unit #(
   parameter int VOICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nvsq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nvsq_pkg::rsp_type rsp_payload
);
   import nvsq_pkg::*;

   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW = $clog2(VOICES + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   req_type           item_ff;
   logic [CW-1:0]     issue_cnt_ff;
   logic              proc_valid_ff;
   logic [IW-1:0]     proc_idx_ff;
   voice_type         rd_data_ff;
   voice_type         voice_mem_ff [VOICES];
   logic [VOICES-1:0] entry_valid_ff;
   logic              found_ff;
   logic [2:0]        index_ff;
   logic [7:0]        toggle_ff;
   logic [7:0]        release_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              accept;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   logic              walk_done;
   logic              rsp_free;
   voice_type         upd_entry;
   voice_flags_type   upd_flags;
   logic [7:0]        voice_bit;

   // handshake and walk control
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rd_en     = (state_ff == S_WALK) && (issue_cnt_ff != CW'(VOICES));
   assign rd_addr   = issue_cnt_ff[IW-1:0];
   assign wr_en     = proc_valid_ff;
   assign walk_done = (state_ff == S_WALK) && !rd_en && !proc_valid_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign voice_bit = 8'(1) << proc_idx_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept)    state_in = S_WALK;
         S_WALK:   if (walk_done) state_in = S_FINISH;
         S_FINISH: if (rsp_free)  state_in = S_IDLE;
         default:                 state_in = S_IDLE;
      endcase
   end

   // voice update logic
   nvsq_voice_update u_update (
      .item  (item_ff),
      .cur   (rd_data_ff),
      .open  (!found_ff),
      .nxt   (upd_entry),
      .flags (upd_flags)
   );

   // voice memory: registered read, write back of the processed entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_valid_ff[rd_addr] ? voice_mem_ff[rd_addr] : '0;
      end
      if (wr_en) begin
         voice_mem_ff[proc_idx_ff] <= upd_entry;
      end
   end

   // control state and result accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         issue_cnt_ff   <= '0;
         proc_valid_ff  <= 1'b0;
         proc_idx_ff    <= '0;
         entry_valid_ff <= '0;
         found_ff       <= 1'b0;
         index_ff       <= '0;
         toggle_ff      <= '0;
         release_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         proc_valid_ff <= rd_en;
         proc_idx_ff   <= rd_addr;
         if (accept) begin
            issue_cnt_ff <= '0;
            found_ff     <= 1'b0;
            index_ff     <= '0;
            toggle_ff    <= '0;
            release_ff   <= '0;
         end else if (rd_en) begin
            issue_cnt_ff <= issue_cnt_ff + CW'(1);
         end
         if (wr_en) begin
            entry_valid_ff[proc_idx_ff] <= 1'b1;
            if (upd_flags.toggled)  toggle_ff  <= toggle_ff | voice_bit;
            if (upd_flags.released) release_ff <= release_ff | voice_bit;
            if (upd_flags.taken) begin
               found_ff <= 1'b1;
               index_ff <= 3'(proc_idx_ff);
            end
         end
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_FINISH) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_FINISH) && rsp_free) begin
         rsp_ff.toggle_mask   <= toggle_ff;
         rsp_ff.voice_found   <= found_ff;
         rsp_ff.voice_index   <= index_ff;
         rsp_ff.released_mask <= release_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_WALK))
      else $error("voice memory written outside the walk");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_cnt_ff <= CW'(VOICES))
      else $error("read counter ran past the voice count");

   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == S_WALK) && (issue_cnt_ff == '0)))
      else $error("walk did not start from the first voice");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && rsp_free) |=> rsp_valid_ff)
      else $error("finished item not presented");

   a_found_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.voice_found) |->
         ((rsp_ff.toggle_mask == 8'd0) && (rsp_ff.released_mask == 8'd0)))
      else $error("note on result carries tick or release bits");
`endif

endmodule

`default_nettype wire

// File: dv/nvsq_voice_checker.sv
// Checker for the square-wave tone generator: voice model, queue of owed results, comparison.
module nvsq_voice_checker #(
   parameter int VOICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  nvsq_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  nvsq_pkg::rsp_type rsp_payload,
   output int                mismatch_count,
   output int                results_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import nvsq_pkg::*;

   // 2^(k/12) scaled by 10^12, k = 0..11
   localparam logic [63:0] ROOT_TWELFTH [12] = '{
      64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115003,
      64'd1259921049895, 64'd1334839854170, 64'd1414213562373, 64'd1498307076877,
      64'd1587401051968, 64'd1681792830507, 64'd1781797436281, 64'd1887748625363
   };
   localparam int REPORT_LIMIT = 10;

   // Model of the voice bank
   logic        voice_on   [VOICES];
   logic [6:0]  voice_key  [VOICES];
   logic [15:0] voice_half [VOICES];
   logic [15:0] voice_left [VOICES];
   rsp_type     owed_results [$];

   // Half period in us: floor(25000/11 * 2^((57 - note)/12)), saturated to 16 bits
   function automatic logic [15:0] half_period_us(int unsigned note_num);
      int unsigned steps_down;
      int unsigned octave;
      int unsigned semis;
      logic [63:0] scaled;
      logic [63:0] divisor;
      logic [63:0] quotient;
      steps_down = 129 - note_num;
      octave     = steps_down / 12;
      semis      = steps_down % 12;
      scaled     = ROOT_TWELFTH[semis] * 64'd25000;
      divisor    = 64'd11000000000000;
      if (octave >= 6) begin
         scaled = scaled << (octave - 6);
      end else begin
         divisor = divisor << (6 - octave);
      end
      quotient = scaled / divisor;
      return (quotient > 64'hFFFF) ? 16'hFFFF : quotient[15:0];
   endfunction

   // Apply one item to the voice bank and work out its result
   function automatic rsp_type advance_voices(req_type item);
      rsp_type res;
      res = '0;
      case (item.operation)
         OP_NOTE_ON: begin
            for (int v = 0; v < VOICES; v++) begin
               if (!voice_on[v] && !res.voice_found) begin
                  // countdown is left as it is
                  voice_on[v]     = 1'b1;
                  voice_key[v]    = item.note;
                  voice_half[v]   = half_period_us(item.note);
                  res.voice_found = 1'b1;
                  res.voice_index = 3'(v);
               end
            end
         end
         OP_NOTE_OFF: begin
            for (int v = 0; v < VOICES; v++) begin
               if (voice_on[v] && voice_key[v] == item.note) begin
                  voice_on[v]          = 1'b0;
                  res.released_mask[v] = 1'b1;
               end
            end
         end
         OP_TICK: begin
            for (int v = 0; v < VOICES; v++) begin
               if (voice_on[v] && voice_left[v] == 16'd0) begin
                  res.toggle_mask[v] = 1'b1;
                  voice_left[v]      = voice_half[v];
               end
               // idle voices count down too, floor at zero
               if (voice_left[v] > item.elapsed_us) begin
                  voice_left[v] = voice_left[v] - item.elapsed_us;
               end else begin
                  voice_left[v] = 16'd0;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Track items in, compare results out
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            voice_on[v]   = 1'b0;
            voice_key[v]  = '0;
            voice_half[v] = '0;
            voice_left[v] = '0;
         end
         owed_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected item: toggle=%02h found=%0d index=%0d rel=%02h",
                           $realtime, rsp_payload.toggle_mask, rsp_payload.voice_found,
                           rsp_payload.voice_index, rsp_payload.released_mask);
               end
            end else begin
               want = owed_results.pop_front();
               if (rsp_payload !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("%0t: expected toggle=%02h found=%0d index=%0d rel=%02h,",
                            $realtime, want.toggle_mask, want.voice_found,
                            want.voice_index, want.released_mask);
                     $display(" got toggle=%02h found=%0d index=%0d rel=%02h",
                              rsp_payload.toggle_mask, rsp_payload.voice_found,
                              rsp_payload.voice_index, rsp_payload.released_mask);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            owed_results.insert(owed_results.size(), advance_voices(req_payload));
         end
      end
      results_owed = owed_results.size();
   end

endmodule

// File: dv/note_voice_square_wave_generator_unit_tb.sv
// Testbench top of the square-wave tone generator: clock, reset, stimulus and verdict.
module note_voice_square_wave_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nvsq_pkg::*;

   localparam logic [1:0] OP_SPARE    = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         PHASE_ITEMS = 125;
   localparam int         HOLD_CYCLES = 400;
   localparam int         DRAIN_CYCLES = 40;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int mismatch_count;
   int results_owed;
   int cycle_count = 0;
   int send_pct    = 0;
   int recv_pct    = 0;
   logic hold_off  = 1'b0;

   note_voice_square_wave_generator_unit #(.VOICES(8)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   nvsq_voice_checker #(.VOICES(8)) voice_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("note_voice_square_wave_generator_unit: mismatch");
         $finish;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_stall = hold_off || (recv_pct != 0 && $urandom_range(99) < recv_pct);
   end

   function automatic req_type make_item(logic [1:0] op, logic [6:0] note, logic [15:0] us);
      req_type item;
      item.operation  = op;
      item.note       = note;
      item.elapsed_us = us;
      return item;
   endfunction

   // Mostly playable sequences: notes from a narrow band so note offs hit, short ticks
   function automatic req_type random_item();
      req_type     item;
      int unsigned pick;
      item.note       = 7'($urandom_range(127));
      item.elapsed_us = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 32) begin
         item.operation = OP_NOTE_ON;
      end else if (pick < 55) begin
         item.operation = OP_NOTE_OFF;
      end else if (pick < 95) begin
         item.operation = OP_TICK;
      end else begin
         item.operation = OP_SPARE;
      end
      if ($urandom_range(99) < 75) begin
         item.note = 7'($urandom_range(67, 60));
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
         item.elapsed_us = 16'($urandom_range(100));
      end else if (pick < 70) begin
         item.elapsed_us = 16'($urandom_range(5000));
      end else if (pick < 80) begin
         item.elapsed_us = 16'd0;
      end
      return item;
   endfunction

   // Offer one item, called and returning at a falling edge
   task automatic send_item(req_type item);
      while (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Change idling with no item on offer
   task automatic set_idling(int sender, int receiver);
      req_valid = 1'b0;
      @(posedge clock);
      send_pct = sender;
      recv_pct = receiver;
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) begin
         send_item(random_item());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty tick, fill the bank, no idle voice, extremes of time
      send_item(make_item(OP_TICK, 7'd0, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd0, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd127, 16'hFFFF));
      send_item(make_item(OP_NOTE_ON, 7'd69, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd69, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd60, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd1, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd126, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd64, 16'd0));
      send_item(make_item(OP_NOTE_ON, 7'd100, 16'd0));
      send_item(make_item(OP_TICK, 7'd0, 16'd0));
      send_item(make_item(OP_TICK, 7'd0, 16'hFFFF));
      send_item(make_item(OP_TICK, 7'd0, 16'd1));
      // note off hitting two voices, then one hitting none
      send_item(make_item(OP_NOTE_OFF, 7'd69, 16'd0));
      send_item(make_item(OP_NOTE_OFF, 7'd50, 16'd0));
      // freed voice keeps its running countdown
      send_item(make_item(OP_NOTE_ON, 7'd5, 16'd0));
      send_item(make_item(OP_TICK, 7'h7F, 16'hAAAA));
      send_item(make_item(OP_SPARE, 7'h55, 16'h5555));
      send_item(make_item(OP_TICK, 7'h2A, 16'h5555));
      send_item(make_item(OP_NOTE_OFF, 7'd127, 16'd0));
      send_item(make_item(OP_NOTE_OFF, 7'd0, 16'd0));
      send_item(make_item(OP_TICK, 7'd0, 16'd30));

      // No idling, with a long receiver hold-off so the input backs up
      fork
         begin
            @(posedge clock);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
         send_random(PHASE_ITEMS);
      join

      set_idling(48, 0);
      send_random(PHASE_ITEMS);
      set_idling(0, 48);
      send_random(PHASE_ITEMS);
      set_idling(18, 18);
      send_random(PHASE_ITEMS);
      req_valid = 1'b0;

      // Drain
      while (results_owed != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("note_voice_square_wave_generator_unit: match");
      end else begin
         $display("note_voice_square_wave_generator_unit: mismatch");
      end
      $finish;
   end

endmodule
